### sv/pgmpp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmpp_pkg
// Shared types and codes of the P2 grey-map text parser: result record,
// result kinds, error codes and the push request into the result queue.
// ----------------------------------------------------------------------------
package pgmpp_pkg;

  // fixed field widths of a result
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned SIZE_W  = 13;

  // result queue depth, a power of two of at least two
  localparam int unsigned RES_DEPTH = 4;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_PIXEL  = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NO_HEADER = 3'd0,
    ERR_NOT_P2    = 3'd1,
    ERR_BAD_DIMS  = 3'd2,
    ERR_NOT_255   = 3'd3,
    ERR_TRUNCATED = 3'd4,
    ERR_TOO_LARGE = 3'd5
  } err_e;

  typedef struct packed {
    kind_e               kind;
    logic [VALUE_W-1:0]  value;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    column;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
    err_e                error;
    logic                complete;
    logic                last;
  } result_t;

  // up to two results produced by one character
  typedef struct packed {
    logic [1:0]          count;
    result_t [1:0]       res;
  } push_t;

endpackage

### sv/pgmpp_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmpp_parser
// Parse state of the P2 text decoder. Each accepted character updates the
// state in one pass and requests zero, one or two results.
// ----------------------------------------------------------------------------
module pgmpp_parser #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          char_i,
  input  logic                eob_i,
  output pgmpp_pkg::push_t    push_o
);

  localparam int unsigned DW = $clog2(MAX_DIM + 2);
  localparam logic [DW-1:0]   DIM_MAX = DW'(MAX_DIM);
  localparam logic [DW-1:0]   DIM_SAT = DW'(MAX_DIM + 1);
  localparam logic [DW+3:0]   DIM_SAT_X = (DW+4)'(MAX_DIM + 1);

  // parse phases
  localparam logic [3:0] PH_LEAD     = 4'd0;
  localparam logic [3:0] PH_LINE1    = 4'd1;
  localparam logic [3:0] PH_LINE1_OK = 4'd2;
  localparam logic [3:0] PH_DIMGAP   = 4'd3;
  localparam logic [3:0] PH_DIM_WS   = 4'd4;
  localparam logic [3:0] PH_DIM_NUM  = 4'd5;
  localparam logic [3:0] PH_DIMREST  = 4'd6;
  localparam logic [3:0] PH_MAXGAP   = 4'd7;
  localparam logic [3:0] PH_MAX      = 4'd8;
  localparam logic [3:0] PH_PIX      = 4'd9;
  localparam logic [3:0] PH_DONE     = 4'd10;

  // pixel token states
  localparam logic [1:0] TS_IDLE = 2'd0;
  localparam logic [1:0] TS_LEAD = 2'd1;
  localparam logic [1:0] TS_NUM  = 2'd2;
  localparam logic [1:0] TS_TAIL = 2'd3;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_FIVE  = 8'h35;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_P     = 8'h50;

  // dimension digit step, saturating just above the limit
  function automatic logic [DW-1:0] dim_mac(input logic [DW-1:0] a, input logic [3:0] d);
    logic [DW+3:0] p;
    p = ({4'b0, a} << 3) + ({4'b0, a} << 1) + (DW+4)'(d);
    if (p > DIM_SAT_X) begin
      return DIM_SAT;
    end
    return p[DW-1:0];
  endfunction

  logic [3:0]    phase_q, phase_d;
  logic          prev_p_q, prev_p_d;
  logic [DW-1:0] nacc_q, nacc_d;
  logic          nneg_q, nneg_d;
  logic          nhas_q, nhas_d;
  logic          wseen_q, wseen_d;
  logic [DW-1:0] w_q, w_d;
  logic [DW-1:0] h_q, h_d;
  logic [1:0]    pos_q, pos_d;
  logic          mism_q, mism_d;
  logic [7:0]    pacc_q, pacc_d;
  logic          pneg_q, pneg_d;
  logic [1:0]    ts_q, ts_d;
  logic [DW-1:0] row_q, row_d;
  logic [DW-1:0] col_q, col_d;

  logic          c_nl, c_space, c_digit, c_sign;
  logic [3:0]    c_val;
  logic [DW-1:0] nval;
  logic          empty;
  logic          row_end, col_wrap, pix_last;
  logic [7:0]    pix_val;
  logic [7:0]    max_char;
  logic [1:0]    ts_v;
  logic [1:0]    pos_v;
  logic          mism_v;
  logic          go_ws, go_rest, go_max, tok_skip;
  logic          do_header, do_pixel, do_fail;
  pgmpp_pkg::err_e     fail_code;
  pgmpp_pkg::result_t  res_v [2];
  logic [1:0]          n_v;

  // character classes
  assign c_nl    = (char_i == CH_NL);
  assign c_space = (char_i inside {[8'h09:8'h0D], CH_SPACE});
  assign c_digit = (char_i inside {[CH_ZERO:CH_NINE]});
  assign c_sign  = (char_i == CH_PLUS) || (char_i == CH_MINUS);
  assign c_val   = 4'(char_i - CH_ZERO);

  // values taken from the current state
  assign nval     = nneg_q ? '0 : nacc_q;
  assign empty    = (w_q == '0) || (h_q == '0);
  assign row_end  = (({1'b0, row_q} + 1'b1) == {1'b0, h_q});
  assign col_wrap = (({1'b0, col_q} + 1'b1) == {1'b0, w_q});
  assign pix_last = row_end && col_wrap;
  assign pix_val  = pneg_q ? 8'(8'd0 - pacc_q) : pacc_q;

  // next state and results of one character
  always_comb begin
    phase_d = phase_q;  prev_p_d = prev_p_q;
    nacc_d  = nacc_q;   nneg_d   = nneg_q;   nhas_d = nhas_q;
    wseen_d = wseen_q;  w_d      = w_q;      h_d    = h_q;
    pos_d   = pos_q;    mism_d   = mism_q;
    pacc_d  = pacc_q;   pneg_d   = pneg_q;   ts_d   = ts_q;
    row_d   = row_q;    col_d    = col_q;
    go_ws = 1'b0; go_rest = 1'b0; go_max = 1'b0; tok_skip = 1'b0;
    do_header = 1'b0; do_pixel = 1'b0; do_fail = 1'b0;
    fail_code = pgmpp_pkg::ERR_NO_HEADER;
    pos_v = pos_q; mism_v = mism_q; ts_v = ts_q;
    max_char = CH_NUL;
    res_v[0] = '0; res_v[1] = '0; n_v = 2'd0;

    if (accept_i && (eob_i || char_i == CH_NUL)) begin
      // end of text: close whatever is open
      case (phase_q)
        PH_LEAD: begin
          do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_NO_HEADER;
        end
        PH_LINE1: begin
          do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_NOT_P2;
        end
        PH_LINE1_OK, PH_DIMGAP, PH_DIM_WS: begin
          do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_BAD_DIMS;
        end
        PH_DIM_NUM: begin
          do_fail = 1'b1;
          if (!nhas_q || !wseen_q) begin
            fail_code = pgmpp_pkg::ERR_BAD_DIMS;
          end else begin
            h_d = nval;
            fail_code = (w_q > DIM_MAX || nval > DIM_MAX) ?
                        pgmpp_pkg::ERR_TOO_LARGE : pgmpp_pkg::ERR_NOT_255;
          end
        end
        PH_DIMREST, PH_MAXGAP: begin
          do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_NOT_255;
        end
        PH_MAX: begin
          do_fail = 1'b1;
          if (!mism_q && pos_q == 2'd3) begin
            do_header = 1'b1;
            do_fail   = !empty;
            fail_code = pgmpp_pkg::ERR_TRUNCATED;
          end else begin
            fail_code = pgmpp_pkg::ERR_NOT_255;
          end
        end
        PH_PIX: begin
          do_pixel  = (ts_q != TS_IDLE);
          do_fail   = !(do_pixel && pix_last);
          fail_code = pgmpp_pkg::ERR_TRUNCATED;
        end
        default: ;
      endcase
    end else if (accept_i) begin
      case (phase_q)
        PH_LEAD: begin
          if (!c_space) begin
            phase_d  = PH_LINE1;
            prev_p_d = (char_i == CH_P);
          end
        end
        PH_LINE1: begin
          if (c_nl) begin
            do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_NOT_P2;
          end else if (prev_p_q && char_i == CH_TWO) begin
            phase_d = PH_LINE1_OK;
          end else begin
            prev_p_d = (char_i == CH_P);
          end
        end
        PH_LINE1_OK: begin
          if (c_nl) phase_d = PH_DIMGAP;
        end
        PH_DIMGAP: begin
          if (!c_nl) begin
            wseen_d = 1'b0;
            go_ws   = 1'b1;
          end
        end
        PH_DIM_WS: go_ws = 1'b1;
        PH_DIM_NUM: begin
          if (c_digit) begin
            nacc_d = dim_mac(nacc_q, c_val);
            nhas_d = 1'b1;
          end else if (!nhas_q) begin
            do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_BAD_DIMS;
          end else if (!wseen_q) begin
            w_d     = nval;
            wseen_d = 1'b1;
            go_ws   = 1'b1;
          end else begin
            h_d = nval;
            if (w_q > DIM_MAX || nval > DIM_MAX) begin
              do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_TOO_LARGE;
            end else begin
              go_rest = 1'b1;
            end
          end
        end
        PH_DIMREST: go_rest = 1'b1;
        PH_MAXGAP: begin
          if (!c_nl) begin
            pos_v  = 2'd0;
            mism_v = 1'b0;
            go_max = 1'b1;
          end
        end
        PH_MAX: go_max = 1'b1;
        PH_PIX: begin
          if (char_i == CH_SPACE || c_nl) begin
            do_pixel = (ts_q != TS_IDLE);
          end else begin
            // inside a pixel token, atoi style
            if (ts_v == TS_IDLE) begin
              ts_v = TS_LEAD; pacc_d = 8'd0; pneg_d = 1'b0;
            end
            if (ts_v == TS_LEAD) begin
              if (c_space) begin
                tok_skip = 1'b1;
              end else if (c_sign) begin
                pneg_d = (char_i == CH_MINUS); ts_v = TS_NUM; tok_skip = 1'b1;
              end else begin
                ts_v = TS_NUM;
              end
            end else if (ts_v != TS_NUM) begin
              tok_skip = 1'b1;
            end
            if (!tok_skip) begin
              if (c_digit) begin
                pacc_d = (pacc_d << 3) + (pacc_d << 1) + {4'b0, c_val};
              end else begin
                ts_v = TS_TAIL;
              end
            end
            ts_d = ts_v;
          end
        end
        default: ;
      endcase

      // between or at the start of a dimension
      if (go_ws) begin
        phase_d = PH_DIM_WS;
        if (c_nl) begin
          do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_BAD_DIMS;
        end else if (!c_space) begin
          nacc_d = '0; nhas_d = 1'b0; nneg_d = 1'b0;
          if (c_sign) begin
            nneg_d  = (char_i == CH_MINUS);
            phase_d = PH_DIM_NUM;
          end else if (c_digit) begin
            nacc_d  = dim_mac('0, c_val);
            nhas_d  = 1'b1;
            phase_d = PH_DIM_NUM;
          end else begin
            do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_BAD_DIMS;
          end
        end
      end

      // rest of the size line
      if (go_rest) begin
        phase_d = c_nl ? PH_MAXGAP : PH_DIMREST;
      end

      // matching the maximum value line
      if (go_max) begin
        phase_d = PH_MAX;
        case (pos_v)
          2'd0:    max_char = CH_TWO;
          2'd1:    max_char = CH_FIVE;
          2'd2:    max_char = CH_FIVE;
          default: max_char = CH_NUL;
        endcase
        if (c_nl) begin
          if (!mism_v && pos_v == 2'd3) begin
            do_header = 1'b1;
          end else begin
            do_fail = 1'b1; fail_code = pgmpp_pkg::ERR_NOT_255;
          end
        end else if (pos_v == 2'd3 || char_i != max_char) begin
          mism_v = 1'b1;
        end else begin
          pos_v = pos_v + 2'd1;
        end
        pos_d  = pos_v;
        mism_d = mism_v;
      end
    end

    // header result
    if (do_header) begin
      res_v[n_v[0]] = '0;
      res_v[n_v[0]].kind     = pgmpp_pkg::KIND_HEADER;
      res_v[n_v[0]].width    = pgmpp_pkg::SIZE_W'(w_q);
      res_v[n_v[0]].height   = pgmpp_pkg::SIZE_W'(h_q);
      res_v[n_v[0]].complete = empty;
      n_v     = n_v + 2'd1;
      phase_d = empty ? PH_DONE : PH_PIX;
      ts_d    = TS_IDLE;
      row_d   = '0;
      col_d   = '0;
    end

    // pixel result and position advance
    if (do_pixel) begin
      res_v[n_v[0]] = '0;
      res_v[n_v[0]].kind     = pgmpp_pkg::KIND_PIXEL;
      res_v[n_v[0]].value    = pix_val;
      res_v[n_v[0]].row      = pgmpp_pkg::POS_W'(row_q);
      res_v[n_v[0]].column   = pgmpp_pkg::POS_W'(col_q);
      res_v[n_v[0]].complete = pix_last;
      n_v  = n_v + 2'd1;
      ts_d = TS_IDLE;
      if (col_wrap) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
      if (pix_last) phase_d = PH_DONE;
    end

    // error result
    if (do_fail) begin
      res_v[n_v[0]] = '0;
      res_v[n_v[0]].kind  = pgmpp_pkg::KIND_ERROR;
      res_v[n_v[0]].error = fail_code;
      n_v     = n_v + 2'd1;
      phase_d = PH_DONE;
    end

    // end of text always closes the image
    if (accept_i && (eob_i || char_i == CH_NUL)) begin
      phase_d = PH_DONE;
    end

    // end mark restarts the parser
    if (accept_i && eob_i) begin
      phase_d = PH_LEAD;  prev_p_d = 1'b0;
      nacc_d  = '0;       nneg_d   = 1'b0;  nhas_d = 1'b0;
      wseen_d = 1'b0;     w_d      = '0;    h_d    = '0;
      pos_d   = 2'd0;     mism_d   = 1'b0;
      pacc_d  = 8'd0;     pneg_d   = 1'b0;  ts_d   = TS_IDLE;
      row_d   = '0;       col_d    = '0;
    end

    // mark the last result of this character
    if (n_v == 2'd1) res_v[0].last = 1'b1;
    if (n_v == 2'd2) res_v[1].last = 1'b1;
  end

  assign push_o.count  = n_v;
  assign push_o.res[0] = res_v[0];
  assign push_o.res[1] = res_v[1];

  // parse state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;  prev_p_q <= 1'b0;
      nacc_q  <= '0;       nneg_q   <= 1'b0;  nhas_q <= 1'b0;
      wseen_q <= 1'b0;     w_q      <= '0;    h_q    <= '0;
      pos_q   <= 2'd0;     mism_q   <= 1'b0;
      pacc_q  <= 8'd0;     pneg_q   <= 1'b0;  ts_q   <= TS_IDLE;
      row_q   <= '0;       col_q    <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;  prev_p_q <= prev_p_d;
      nacc_q  <= nacc_d;   nneg_q   <= nneg_d;  nhas_q <= nhas_d;
      wseen_q <= wseen_d;  w_q      <= w_d;     h_q    <= h_d;
      pos_q   <= pos_d;    mism_q   <= mism_d;
      pacc_q  <= pacc_d;   pneg_q   <= pneg_d;  ts_q   <= ts_d;
      row_q   <= row_d;    col_q    <= col_d;
    end
  end

endmodule

### sv/pgmpp_res_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgmpp_res_fifo
// Small result queue: takes up to two results per cycle from the parser and
// hands them out one per cycle on the output side while the receiver is ready.
// ----------------------------------------------------------------------------
module pgmpp_res_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pgmpp_pkg::push_t     push_i,
  output logic                 room_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output pgmpp_pkg::result_t   res_o
);

  localparam int unsigned DEPTH = pgmpp_pkg::RES_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  pgmpp_pkg::result_t mem_q [DEPTH];
  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign room_o  = (cnt_q <= CW'(DEPTH - 2));
  assign res_o   = mem_q[rp_q];

  // pointer and fill bookkeeping
  always_comb begin
    wp_d  = wp_q + AW'(push_i.count);
    rp_d  = rp_q + AW'(pop);
    cnt_d = cnt_q + CW'(push_i.count) - CW'(pop);
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wp_q] <= push_i.res[0];
    end
    if (push_i.count == 2'd2) begin
      mem_q[wp_q + AW'(1)] <= push_i.res[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

### sv/pgm_ascii_pixel_parser_unit.sv
`timescale 1ns / 1ps
// Results of an accepted character are registered in the result queue and leave it in order.
// Throughput: one character per cycle; a character that yields two results hands them
// out one at a time, and input stalls while the four-entry result queue lacks room.
// Reset: rst_ni clears the parse state to the leading-whitespace phase and empties
// the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// pgm_ascii_pixel_parser_unit
// P2 grey-map text decoder: header check, size and maximum value lines, then
// pixel tokens with their row and column.
// ----------------------------------------------------------------------------
module pgm_ascii_pixel_parser_unit #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_buffer
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] pixel_value, [19:8] pixel_row, [31:20] pixel_column,
  // [44:32] image_width, [57:45] image_height, [60:58] error_code,
  // [61] image_complete, [63:62] zero
  output logic [63:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast    // last_of_run
);

  logic               in_acc;
  logic               room;
  pgmpp_pkg::push_t   push;
  pgmpp_pkg::result_t res;

  // request taken whenever the queue has room for two results
  assign s_axis_tready = room;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  pgmpp_parser #(
    .MAX_DIM (MAX_DIM)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .char_i   (s_axis_tdata),
    .eob_i    (s_axis_tlast),
    .push_o   (push)
  );

  pgmpp_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (res)
  );

  // output packing
  assign m_axis_tdata = {2'b00, res.complete, res.error, res.height, res.width,
                         res.column, res.row, res.value};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
